/* src/sbh_pkg.sv */
package sbh_pkg;

	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned HASH_WORDS  = 8;
	localparam int unsigned ROUNDS      = 64;

	localparam logic [5:0] FILL_LAST  = 6'b111111;
	localparam logic [5:0] FILL_LEN   = 6'd56;
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [4:0] LOAD_LAST  = 5'd16;
	localparam logic [4:0] FINAL_LAST = 5'd8;
	localparam logic [1:0] WORD_LAST  = 2'd3;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_FINAL = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

/* src/sha256_byte_stream_hasher.sv */
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  data_byte, has_byte, last_byte
// out      output     out_valid/out_ready  digest_word, word_index, last_word
//
// a byte transaction completes when in_valid and in_ready are high; the byte that fills a
// block holds in_ready low while the block and hash state load from memory, the
// 64 rounds run on the single round unit and the result folds into the hash memory
// a last transaction pads one byte a cycle, compresses once or twice, then
// presents four digest words that wait on out_ready
// arst_n clears control state; unwritten hash memory entries read as the initial values
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	sbh_pkg::state_t state_q;
	logic [5:0]   fill_q;
	logic [60:0]  byte_total_q;
	logic         msg_end_q;
	logic         first_q;
	logic         len_q;
	logic         fin_q;
	logic [4:0]   cnt_q;
	logic [5:0]   rnd_q;
	logic [1:0]   oidx_q;
	logic [7:0]   hvalid_q;

	logic [23:0]  word_q;
	logic [31:0]  w_q [sbh_pkg::BLOCK_WORDS];
	logic [31:0]  v_q [sbh_pkg::HASH_WORDS];
	logic [255:0] dig_q;

	logic [31:0]  block_mem_q [sbh_pkg::BLOCK_WORDS];
	logic [31:0]  hash_mem_q [sbh_pkg::HASH_WORDS];
	logic [31:0]  brd_q;
	logic [31:0]  hmem_rd_q;
	logic [31:0]  hiv_q;
	logic         hsel_q;

	logic         in_acc;
	logic         out_acc;
	logic         put_en;
	logic [7:0]   put_b;
	logic [7:0]   pad_b;
	logic [5:0]   fill_next;
	logic         wrap;
	logic [63:0]  len_bits;
	logic [31:0]  hrd;
	logic [31:0]  hsum;
	logic [2:0]   hw_addr;
	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [31:0]  ch;
	logic [31:0]  maj;
	logic [31:0]  w_new;

	assign in_ready  = (state_q == sbh_pkg::ST_IDLE);
	assign out_valid = (state_q == sbh_pkg::ST_OUT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	assign digest_word = dig_q[255:192];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == sbh_pkg::WORD_LAST);

	assign len_bits  = {byte_total_q, 3'b000};
	assign pad_b     = first_q ? sbh_pkg::PAD_MARK :
		len_q ? len_bits[{~fill_q[2:0], 3'b000} +: 8] : 8'h00;
	assign put_en    = (in_acc && has_byte) || (state_q == sbh_pkg::ST_PAD);
	assign put_b     = (state_q == sbh_pkg::ST_PAD) ? pad_b : data_byte;
	assign fill_next = fill_q + 6'd1;
	assign wrap      = put_en && (fill_q == sbh_pkg::FILL_LAST);

	assign hrd     = hsel_q ? hmem_rd_q : hiv_q;
	assign hsum    = hrd + v_q[0];
	assign hw_addr = 3'(cnt_q - 5'd1);

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + sbh_pkg::big_sigma1(v_q[4]) + ch + sbh_pkg::ROUND_K[rnd_q] + w_q[0];
	assign t2  = sbh_pkg::big_sigma0(v_q[0]) + maj;
	assign w_new = w_q[0] + sbh_pkg::small_sigma0(w_q[1]) + w_q[9]
		+ sbh_pkg::small_sigma1(w_q[14]);

	// block memory: written four bytes at a time, read during load
	always_ff @(posedge clk) begin
		if (put_en && (fill_q[1:0] == 2'b11)) begin
			block_mem_q[fill_q[5:2]] <= {word_q, put_b};
		end
		brd_q <= block_mem_q[cnt_q[3:0]];
	end

	// hash memory: read during load and final, written back during final
	always_ff @(posedge clk) begin
		if ((state_q == sbh_pkg::ST_FINAL) && (cnt_q != 5'd0)) begin
			hash_mem_q[hw_addr] <= fin_q ? sbh_pkg::INIT_HASH[hw_addr] : hsum;
		end
		hmem_rd_q <= hash_mem_q[cnt_q[2:0]];
		hiv_q     <= sbh_pkg::INIT_HASH[cnt_q[2:0]];
		hsel_q    <= hvalid_q[cnt_q[2:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sbh_pkg::ST_IDLE;
			fill_q       <= '0;
			byte_total_q <= '0;
			msg_end_q    <= 1'b0;
			first_q      <= 1'b0;
			len_q        <= 1'b0;
			fin_q        <= 1'b0;
			cnt_q        <= '0;
			rnd_q        <= '0;
			oidx_q       <= '0;
			hvalid_q     <= '0;
		end else begin
			if (put_en) begin
				fill_q <= fill_next;
			end
			case (state_q)
				sbh_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (has_byte) begin
							byte_total_q <= byte_total_q + 61'd1;
						end
						if (last_byte) begin
							msg_end_q <= 1'b1;
							first_q   <= 1'b1;
							len_q     <= 1'b0;
						end
						if (wrap) begin
							fin_q   <= 1'b0;
							cnt_q   <= '0;
							state_q <= sbh_pkg::ST_LOAD;
						end else if (last_byte) begin
							state_q <= sbh_pkg::ST_PAD;
						end
					end
				end
				sbh_pkg::ST_PAD: begin
					first_q <= 1'b0;
					if (!len_q) begin
						len_q <= (fill_next == sbh_pkg::FILL_LEN);
					end
					if (wrap) begin
						fin_q   <= len_q;
						cnt_q   <= '0;
						state_q <= sbh_pkg::ST_LOAD;
					end
				end
				sbh_pkg::ST_LOAD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == sbh_pkg::LOAD_LAST) begin
						rnd_q   <= '0;
						state_q <= sbh_pkg::ST_ROUND;
					end
				end
				sbh_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(sbh_pkg::ROUNDS - 1)) begin
						cnt_q   <= '0;
						state_q <= sbh_pkg::ST_FINAL;
					end
				end
				sbh_pkg::ST_FINAL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q != 5'd0) begin
						hvalid_q[hw_addr] <= 1'b1;
					end
					if (cnt_q == sbh_pkg::FINAL_LAST) begin
						if (fin_q) begin
							oidx_q       <= '0;
							msg_end_q    <= 1'b0;
							byte_total_q <= '0;
							state_q      <= sbh_pkg::ST_OUT;
						end else if (msg_end_q) begin
							state_q <= sbh_pkg::ST_PAD;
						end else begin
							state_q <= sbh_pkg::ST_IDLE;
						end
					end
				end
				sbh_pkg::ST_OUT: begin
					if (out_acc) begin
						oidx_q <= oidx_q + 2'd1;
						if (oidx_q == sbh_pkg::WORD_LAST) begin
							state_q <= sbh_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= sbh_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (put_en) begin
			word_q <= {word_q[15:0], put_b};
		end
		case (state_q)
			sbh_pkg::ST_LOAD: begin
				if (cnt_q != 5'd0) begin
					for (int i = 0; i < sbh_pkg::BLOCK_WORDS - 1; i++) begin
						w_q[i] <= w_q[i + 1];
					end
					w_q[sbh_pkg::BLOCK_WORDS - 1] <= brd_q;
				end
				if ((cnt_q != 5'd0) && (cnt_q <= 5'(sbh_pkg::HASH_WORDS))) begin
					for (int i = 0; i < sbh_pkg::HASH_WORDS - 1; i++) begin
						v_q[i] <= v_q[i + 1];
					end
					v_q[sbh_pkg::HASH_WORDS - 1] <= hrd;
				end
			end
			sbh_pkg::ST_ROUND: begin
				v_q[0] <= t1 + t2;
				v_q[1] <= v_q[0];
				v_q[2] <= v_q[1];
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3] + t1;
				v_q[5] <= v_q[4];
				v_q[6] <= v_q[5];
				v_q[7] <= v_q[6];
				for (int i = 0; i < sbh_pkg::BLOCK_WORDS - 1; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[sbh_pkg::BLOCK_WORDS - 1] <= w_new;
			end
			sbh_pkg::ST_FINAL: begin
				if (cnt_q != 5'd0) begin
					for (int i = 0; i < sbh_pkg::HASH_WORDS - 1; i++) begin
						v_q[i] <= v_q[i + 1];
					end
					dig_q <= {dig_q[223:0], hsum};
				end
			end
			sbh_pkg::ST_OUT: begin
				if (out_acc) begin
					dig_q <= {dig_q[191:0], 64'h0};
				end
			end
			default: begin
			end
		endcase
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");

	a_out_block_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_q == 6'd0) && (byte_total_q == 61'd0) && !msg_end_q)
		else $error("digest shown with message state left over");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbh_pkg::ST_LOAD) |-> (cnt_q <= sbh_pkg::LOAD_LAST))
		else $error("load counter out of range");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> in_ready)
		else $error("not idle after last digest word");

	a_len_slot: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == sbh_pkg::ST_PAD) && len_q) |-> (fill_q >= sbh_pkg::FILL_LEN))
		else $error("length bytes outside their slots");

endmodule
